// File: rtl/c8_pkg.sv
// CHIP-8 instruction core: shared types, constants and helper functions.
// No dependencies; used by c8_core, the top level and c8_chk (c8_ram does not use it).
`timescale 1ns / 1ps
`default_nettype none
package c8_pkg;

  localparam int MEM_BYTES   = 65536;
  localparam int MEM_AW      = $clog2(MEM_BYTES);
  localparam int STACK_DEPTH = 16;
  localparam int SW          = $clog2(STACK_DEPTH);
  localparam int SP_W        = $clog2(STACK_DEPTH + 1);
  localparam int NREGS       = 16;
  localparam int RAW         = $clog2(NREGS);

  localparam logic [15:0] PROG_START_RST = 16'h0200;

  // low-byte codes of group 0 and group F
  localparam logic [7:0] OP_CLS  = 8'hE0;
  localparam logic [7:0] OP_RET  = 8'hEE;
  localparam logic [7:0] OP_ADDI = 8'h1E;
  localparam logic [7:0] OP_BCD  = 8'h33;
  localparam logic [7:0] OP_STR  = 8'h55;
  localparam logic [7:0] OP_LDR  = 8'h65;

  localparam logic [RAW-1:0] REG_VF = RAW'(NREGS - 1);

  typedef enum logic [1:0] {
    K_LOAD    = 2'd0,
    K_EXEC    = 2'd1,
    K_COLL    = 2'd2,
    K_RESTART = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    ST_EXEC      = 4'd0,
    ST_LOADED    = 4'd1,
    ST_RESTARTED = 4'd2,
    ST_CLS       = 4'd3,
    ST_DRAW_ROW  = 4'd4,
    ST_DRAW_DONE = 4'd5,
    ST_SELF_JUMP = 4'd6,
    ST_UNKNOWN   = 4'd7,
    ST_STACK_ERR = 4'd8,
    ST_IGNORED   = 4'd9
  } status_e;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_SIMPLE, S_F0, S_F1, S_F2, S_F3, S_EX, S_DO, S_FLAG,
    S_FIN, S_DR_RD, S_DR_EM, S_ST_RD, S_ST_WR, S_LD_RD, S_LD_WR, S_BCD
  } fsm_e;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [MEM_AW-1:0] addr;
    logic [7:0]        wdata;
  } mem_req_t;

  typedef struct packed {
    logic           we;
    logic           re;
    logic [RAW-1:0] addr;
    logic [7:0]     wdata;
  } reg_req_t;

  // last member sits in the low bits of the packed word
  typedef struct packed {
    logic [3:0]  row_index;
    logic [7:0]  sprite_byte;
    logic [7:0]  draw_y;
    logic [7:0]  draw_x;
    logic [15:0] opcode;
    logic [15:0] pc;
    status_e     status;
  } result_t;

  function automatic logic [MEM_AW-1:0] mem_addr(input logic [15:0] a);
    return a[MEM_AW-1:0];
  endfunction

  // {hundreds, tens, ones}, four bits each
  function automatic logic [11:0] bcd8(input logic [7:0] v);
    logic [1:0]  h;
    logic [7:0]  r;
    logic [14:0] p;
    logic [3:0]  t;
    logic [7:0]  o;
    h = (v >= 8'd200) ? 2'd2 : ((v >= 8'd100) ? 2'd1 : 2'd0);
    r = (h == 2'd2) ? v - 8'd200 : ((h == 2'd1) ? v - 8'd100 : v);
    p = 15'(r) * 15'd205;   // r / 10 for r below 100
    t = p[14:11];
    o = r - ({4'd0, t} << 3) - ({4'd0, t} << 1);
    return {2'b00, h, t, o[3:0]};
  endfunction

endpackage
`default_nettype wire

// File: rtl/c8_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module c8_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[addr_i];
    end
  end

endmodule
`default_nettype wire

// File: rtl/c8_core.sv
// Sequencer and datapath of the CHIP-8 core: fetch, decode, register and
// byte-store access, stack, result register. Depends on c8_pkg.
`timescale 1ns / 1ps
`default_nettype none
module c8_core (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [15:0]       cfg_data_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [1:0]        in_kind_i,
  input  wire logic [15:0]       in_addr_i,
  input  wire logic [7:0]        in_data_i,
  input  wire logic              in_coll_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output c8_pkg::result_t        out_res_o,
  output logic                   out_last_o,
  output c8_pkg::mem_req_t       mem_req_o,
  input  wire logic [7:0]        mem_rdata_i,
  output c8_pkg::reg_req_t       reg_req_o,
  input  wire logic [7:0]        reg_rdata_i
);
  import c8_pkg::*;

  fsm_e               state_q, state_d;
  logic [15:0]        prog_q;
  logic [15:0]        pc_q, pc_d, i_q, i_d, next_q, next_d, op_q, op_d;
  logic [SP_W-1:0]    sp_q, sp_d, sp_m1;
  logic [15:0]        stack_q [STACK_DEPTH];
  logic               push;
  logic               run_q, run_d, await_q, await_d, halt_q, halt_d;
  logic               coll_mode_q, coll_mode_d, coll_q, coll_d, flag_q, flag_d;
  logic [NREGS-1:0]   vld_q, vld_d;
  logic [RAW-1:0]     rraddr_q, rraddr_d;
  logic [7:0]         vx_q, vx_d, vy_q, vy_d, rv;
  logic [3:0]         cnt_q, cnt_d;
  logic [11:0]        bcd_q, bcd_d;
  status_e            st_q, st_d;
  result_t            out_q, out_d;
  logic               olast_q, olast_d, ov_q, ov_d;
  logic [MEM_AW-1:0]  clr_q, clr_d;
  logic               accept, out_free;
  logic [3:0]         x, n;
  logic [7:0]         nn;
  logic [15:0]        nnn, pc2, pc4;
  logic               draw_last;

  assign accept   = in_valid_i && in_ready_o;
  assign out_free = !ov_q || out_ready_i;
  assign x        = op_q[11:8];
  assign n        = op_q[3:0];
  assign nn       = op_q[7:0];
  assign nnn      = {4'd0, op_q[11:0]};
  assign pc2      = pc_q + 16'd2;
  assign pc4      = pc_q + 16'd4;
  assign sp_m1    = sp_q - SP_W'(1);
  assign rv       = vld_q[rraddr_q] ? reg_rdata_i : 8'h00;
  assign draw_last = (n == 4'd0) || (cnt_q == n - 4'd1);

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = ov_q;
  assign out_res_o   = out_q;
  assign out_last_o  = olast_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: if (clr_q == '1) state_d = S_IDLE;
      S_IDLE: begin
        if (accept) begin
          case (kind_e'(in_kind_i))
            K_EXEC:  state_d = (run_q && !await_q) ? S_F0 : S_SIMPLE;
            K_COLL:  state_d = await_q ? S_F0 : S_SIMPLE;
            default: state_d = S_SIMPLE;
          endcase
        end
      end
      S_SIMPLE: if (out_free) state_d = S_IDLE;
      S_F0:     state_d = S_F1;
      S_F1:     state_d = S_F2;
      S_F2:     state_d = S_F3;
      S_F3:     state_d = S_EX;
      S_EX:     state_d = S_DO;
      S_DO: begin
        state_d = S_FIN;
        if (!coll_mode_q) begin
          case (op_q[15:12])
            4'h8:    if (n inside {4'h4, 4'h5, 4'h6, 4'h7, 4'hE}) state_d = S_FLAG;
            4'hD:    state_d = S_DR_RD;
            4'hF: begin
              case (nn)
                OP_BCD:  state_d = S_BCD;
                OP_STR:  state_d = S_ST_RD;
                OP_LDR:  state_d = S_LD_RD;
                default: state_d = S_FIN;
              endcase
            end
            default: state_d = S_FIN;
          endcase
        end
      end
      S_FLAG:  state_d = S_FIN;
      S_FIN:   if (out_free) state_d = S_IDLE;
      S_DR_RD: state_d = S_DR_EM;
      S_DR_EM: if (out_free) state_d = draw_last ? S_IDLE : S_DR_RD;
      S_ST_RD: state_d = S_ST_WR;
      S_ST_WR: state_d = (cnt_q == x) ? S_FIN : S_ST_RD;
      S_LD_RD: state_d = S_LD_WR;
      S_LD_WR: state_d = (cnt_q == x) ? S_FIN : S_LD_RD;
      S_BCD:   if (cnt_q == 4'd2) state_d = S_FIN;
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and memory requests
  always_comb begin
    pc_d = pc_q; i_d = i_q; next_d = next_q; op_d = op_q; sp_d = sp_q;
    run_d = run_q; await_d = await_q; halt_d = halt_q;
    coll_mode_d = coll_mode_q; coll_d = coll_q; flag_d = flag_q;
    vld_d = vld_q; rraddr_d = rraddr_q; vx_d = vx_q; vy_d = vy_q;
    cnt_d = cnt_q; bcd_d = bcd_q; st_d = st_q; clr_d = clr_q;
    out_d = out_q; olast_d = olast_q; ov_d = ov_q && !out_ready_i;
    push = 1'b0;
    mem_req_o = '0;
    reg_req_o = '0;
    case (state_q)
      S_CLEAR: begin
        mem_req_o.we   = 1'b1;
        mem_req_o.addr = clr_q;
        clr_d          = clr_q + MEM_AW'(1);
      end
      S_IDLE: begin
        if (accept) begin
          coll_mode_d = 1'b0;
          coll_d      = in_coll_i;
          case (kind_e'(in_kind_i))
            K_LOAD: begin
              mem_req_o.we    = 1'b1;
              mem_req_o.addr  = mem_addr(in_addr_i);
              mem_req_o.wdata = in_data_i;
              st_d            = ST_LOADED;
            end
            K_RESTART: begin
              vld_d = '0; i_d = '0; pc_d = prog_q; sp_d = '0;
              run_d = 1'b1; await_d = 1'b0;
              st_d  = ST_RESTARTED;
            end
            K_COLL: begin
              coll_mode_d = 1'b1;
              st_d        = ST_IGNORED;
            end
            default: st_d = ST_IGNORED;
          endcase
        end
      end
      S_SIMPLE: begin
        if (out_free) begin
          ov_d    = 1'b1;
          out_d   = '{row_index: 4'd0, sprite_byte: 8'd0, draw_y: 8'd0, draw_x: 8'd0,
                      opcode: 16'd0, pc: pc_q, status: st_q};
          olast_d = 1'b1;
        end
      end
      S_F0: begin
        mem_req_o.re   = 1'b1;
        mem_req_o.addr = mem_addr(pc_q);
      end
      S_F1: begin
        op_d[15:8]     = mem_rdata_i;
        mem_req_o.re   = 1'b1;
        mem_req_o.addr = mem_addr(pc_q + 16'd1);
      end
      S_F2: begin
        op_d[7:0]      = mem_rdata_i;
        reg_req_o.re   = 1'b1;
        reg_req_o.addr = op_q[11:8];
        rraddr_d       = op_q[11:8];
      end
      S_F3: begin
        vx_d           = rv;
        reg_req_o.re   = 1'b1;
        reg_req_o.addr = op_q[7:4];
        rraddr_d       = op_q[7:4];
      end
      S_EX: vy_d = rv;
      S_DO: begin
        next_d = pc2;
        st_d   = ST_EXEC;
        halt_d = 1'b0;
        cnt_d  = '0;
        if (coll_mode_q) begin
          reg_req_o = '{we: 1'b1, re: 1'b0, addr: REG_VF, wdata: {7'd0, coll_q}};
          await_d   = 1'b0;
          st_d      = ST_DRAW_DONE;
        end else begin
          case (op_q[15:12])
            4'h0: begin
              if (nn == OP_CLS) begin
                st_d = ST_CLS;
              end else if (nn == OP_RET) begin
                if (sp_q == '0) begin
                  halt_d = 1'b1; st_d = ST_STACK_ERR;
                end else begin
                  sp_d   = sp_m1;
                  next_d = stack_q[sp_m1[SW-1:0]];
                end
              end else begin
                halt_d = 1'b1; st_d = ST_UNKNOWN;
              end
            end
            4'h1: begin
              if (nnn == pc_q) begin
                halt_d = 1'b1; st_d = ST_SELF_JUMP;
              end else begin
                next_d = nnn;
              end
            end
            4'h2: begin
              if (sp_q >= SP_W'(STACK_DEPTH)) begin
                halt_d = 1'b1; st_d = ST_STACK_ERR;
              end else begin
                push   = 1'b1;
                sp_d   = sp_q + SP_W'(1);
                next_d = nnn;
              end
            end
            4'h3: if (vx_q == nn) next_d = pc4;
            4'h4: if (vx_q != nn) next_d = pc4;
            4'h5: begin
              if (n != 4'd0) begin
                halt_d = 1'b1; st_d = ST_UNKNOWN;
              end else if (vx_q == vy_q) begin
                next_d = pc4;
              end
            end
            4'h6: reg_req_o = '{we: 1'b1, re: 1'b0, addr: x, wdata: nn};
            4'h7: reg_req_o = '{we: 1'b1, re: 1'b0, addr: x, wdata: vx_q + nn};
            4'h8: begin
              reg_req_o.we   = 1'b1;
              reg_req_o.addr = x;
              case (n)
                4'h0: reg_req_o.wdata = vy_q;
                4'h1: reg_req_o.wdata = vx_q | vy_q;
                4'h2: reg_req_o.wdata = vx_q & vy_q;
                4'h3: reg_req_o.wdata = vx_q ^ vy_q;
                4'h4: {flag_d, reg_req_o.wdata} = {1'b0, vx_q} + {1'b0, vy_q};
                4'h5: begin
                  reg_req_o.wdata = vx_q - vy_q;
                  flag_d          = (vx_q >= vy_q);
                end
                4'h6: begin
                  reg_req_o.wdata = {1'b0, vy_q[7:1]};
                  flag_d          = vy_q[0];
                end
                4'h7: begin
                  reg_req_o.wdata = vy_q - vx_q;
                  flag_d          = (vy_q >= vx_q);
                end
                4'hE: begin
                  reg_req_o.wdata = {vy_q[6:0], 1'b0};
                  flag_d          = vy_q[7];
                end
                default: begin
                  reg_req_o.we = 1'b0;
                  halt_d       = 1'b1;
                  st_d         = ST_UNKNOWN;
                end
              endcase
            end
            4'h9: begin
              if (n != 4'd0) begin
                halt_d = 1'b1; st_d = ST_UNKNOWN;
              end else if (vx_q != vy_q) begin
                next_d = pc4;
              end
            end
            4'hA: i_d = nnn;
            4'hD: ;
            4'hF: begin
              case (nn)
                OP_ADDI: i_d = i_q + {8'd0, vx_q};
                OP_BCD:  bcd_d = bcd8(vx_q);
                OP_STR, OP_LDR: ;
                default: begin
                  halt_d = 1'b1; st_d = ST_UNKNOWN;
                end
              endcase
            end
            default: begin
              halt_d = 1'b1; st_d = ST_UNKNOWN;
            end
          endcase
        end
      end
      S_FLAG: reg_req_o = '{we: 1'b1, re: 1'b0, addr: REG_VF, wdata: {7'd0, flag_q}};
      S_FIN: begin
        if (out_free) begin
          ov_d    = 1'b1;
          out_d   = '{row_index: 4'd0, sprite_byte: 8'd0, draw_y: 8'd0, draw_x: 8'd0,
                      opcode: op_q, pc: pc_q, status: st_q};
          olast_d = 1'b1;
          if (halt_q) run_d = 1'b0;
          else        pc_d  = next_q;
        end
      end
      S_DR_RD: begin
        mem_req_o.re   = 1'b1;
        mem_req_o.addr = mem_addr(i_q + {12'd0, cnt_q});
      end
      S_DR_EM: begin
        if (out_free) begin
          ov_d    = 1'b1;
          out_d   = '{row_index: cnt_q,
                      sprite_byte: (n != 4'd0) ? mem_rdata_i : 8'd0,
                      draw_y: vy_q, draw_x: vx_q,
                      opcode: op_q, pc: pc_q, status: ST_DRAW_ROW};
          olast_d = draw_last;
          if (draw_last) await_d = 1'b1;
          else           cnt_d   = cnt_q + 4'd1;
        end
      end
      S_ST_RD: begin
        reg_req_o.re   = 1'b1;
        reg_req_o.addr = cnt_q;
        rraddr_d       = cnt_q;
      end
      S_ST_WR: begin
        mem_req_o = '{we: 1'b1, re: 1'b0, addr: mem_addr(i_q), wdata: rv};
        i_d       = i_q + 16'd1;
        cnt_d     = cnt_q + 4'd1;
      end
      S_LD_RD: begin
        mem_req_o.re   = 1'b1;
        mem_req_o.addr = mem_addr(i_q);
      end
      S_LD_WR: begin
        reg_req_o = '{we: 1'b1, re: 1'b0, addr: cnt_q, wdata: mem_rdata_i};
        i_d       = i_q + 16'd1;
        cnt_d     = cnt_q + 4'd1;
      end
      S_BCD: begin
        // ones at I+2, tens at I+1, hundreds at I
        mem_req_o.we   = 1'b1;
        mem_req_o.addr = mem_addr(i_q + 16'd2 - {12'd0, cnt_q});
        case (cnt_q)
          4'd0:    mem_req_o.wdata = {4'd0, bcd_q[3:0]};
          4'd1:    mem_req_o.wdata = {4'd0, bcd_q[7:4]};
          default: mem_req_o.wdata = {4'd0, bcd_q[11:8]};
        endcase
        cnt_d = cnt_q + 4'd1;
      end
      default: ;
    endcase
    if (reg_req_o.we) vld_d[reg_req_o.addr] = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      prog_q  <= PROG_START_RST;
      pc_q    <= PROG_START_RST;
      i_q     <= '0;
      sp_q    <= '0;
      run_q   <= 1'b1;
      await_q <= 1'b0;
      vld_q   <= '0;
      ov_q    <= 1'b0;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) prog_q <= cfg_data_i;
      pc_q    <= pc_d;
      i_q     <= i_d;
      sp_q    <= sp_d;
      run_q   <= run_d;
      await_q <= await_d;
      vld_q   <= vld_d;
      ov_q    <= ov_d;
      clr_q   <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    next_q      <= next_d;
    op_q        <= op_d;
    halt_q      <= halt_d;
    coll_mode_q <= coll_mode_d;
    coll_q      <= coll_d;
    flag_q      <= flag_d;
    rraddr_q    <= rraddr_d;
    vx_q        <= vx_d;
    vy_q        <= vy_d;
    cnt_q       <= cnt_d;
    bcd_q       <= bcd_d;
    st_q        <= st_d;
    out_q       <= out_d;
    olast_q     <= olast_d;
    if (push) stack_q[sp_q[SW-1:0]] <= pc2;
  end

endmodule
`default_nettype wire

// File: rtl/chip8_instruction_core_top.sv
// Top level of the CHIP-8 instruction core: sequencer plus byte store and
// register file RAMs. Depends on c8_pkg, c8_ram, c8_core.
//
//  channel | signals                         | direction | contents
//  --------+---------------------------------+-----------+-------------------------
//  config  | cfg_we_i, cfg_data_i            | in        | program_start
//  input   | s_axis_tvalid/tready/tdata/tuser| in        | load, execute, collision, restart
//  result  | m_axis_tvalid/tready/tdata/tlast| out       | status and draw rows
//
// Load, restart and ignored requests only report a result; most instructions and collision
// replies make two byte fetches and two register reads through single-port RAMs.
// 8XY4/5/6/7/E add a VF write, FX55/FX65 add a read and a write per register, FX33 adds
// three byte writes; DRW adds one byte read per row.
// After reset a clearing pass writes zero to all MEM_BYTES (65536) bytes,
// one per cycle, before the first request is taken.
// A stalled result stalls the core only when a further result is due.
`timescale 1ns / 1ps
`default_nettype none
module chip8_instruction_core_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [15:0] load_address, [23:16] load_data, [24] collision, [31:25] zero
  input  wire logic [31:0] s_axis_tdata,
  // [1:0] kind
  input  wire logic [1:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [3:0] status, [19:4] pc, [35:20] opcode, [43:36] draw_x, [51:44] draw_y,
  // [59:52] sprite_byte, [63:60] row_index
  output logic [63:0]      m_axis_tdata,
  output logic             m_axis_tlast
);
  import c8_pkg::*;

  mem_req_t   mem_req;
  reg_req_t   reg_req;
  logic [7:0] mem_rdata, reg_rdata;
  result_t    res;

  c8_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_kind_i   (s_axis_tuser),
    .in_addr_i   (s_axis_tdata[15:0]),
    .in_data_i   (s_axis_tdata[23:16]),
    .in_coll_i   (s_axis_tdata[24]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (res),
    .out_last_o  (m_axis_tlast),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata),
    .reg_req_o   (reg_req),
    .reg_rdata_i (reg_rdata)
  );

  assign m_axis_tdata = res;

  c8_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .re_i    (mem_req.re),
    .addr_i  (mem_req.addr),
    .wdata_i (mem_req.wdata),
    .rdata_o (mem_rdata)
  );

  c8_ram #(.WIDTH(8), .DEPTH(NREGS)) u_regs (
    .clk_i   (clk_i),
    .we_i    (reg_req.we),
    .re_i    (reg_req.re),
    .addr_i  (reg_req.addr),
    .wdata_i (reg_req.wdata),
    .rdata_o (reg_rdata)
  );

endmodule
`default_nettype wire

// File: rtl/c8_chk.sv
// Port-level checks for the CHIP-8 instruction core, bound to the top level.
// Depends on c8_pkg and chip8_instruction_core_top.
`timescale 1ns / 1ps
`default_nettype none
module c8_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [63:0] m_axis_tdata,
  input wire logic        m_axis_tlast
);
  import c8_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while busy");

  a_only_rows_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[3:0] != ST_DRAW_ROW) |-> m_axis_tlast)
    else $error("non-row result without last");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[3:0] <= ST_IGNORED)
    else $error("status out of range");

endmodule

bind chip8_instruction_core_top c8_chk u_c8_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire
